@@ rtl/dedup_sorted_id_set_core_defines.svh @@
// Assertion macros shared by the dedup sorted id set RTL.
`ifndef DEDUP_SORTED_ID_SET_CORE_DEFINES_SVH
`define DEDUP_SORTED_ID_SET_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`define DSI_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
`else
`define DSI_ASSERT_IMP(lbl, ante, cons, msg)
`define DSI_ASSERT_NXT(lbl, ante, cons, msg)
`define DSI_ASSERT_ALW(lbl, cond, msg)
`endif

`endif

@@ rtl/dsi_pkg.sv @@
// Package for the dedup sorted id set: sizes, status codes, control structs.
`default_nettype none
package dsi_pkg;

  localparam int MaxIds = 64;
  localparam int IdW    = 31;
  localparam int CntW   = $clog2(MaxIds + 1);
  localparam int StatW  = 2;
  localparam int InDataW  = ((IdW + 7) / 8) * 8;
  localparam int OutRawW  = StatW + 1 + CntW;
  localparam int OutDataW = ((OutRawW + 7) / 8) * 8;

  localparam logic [StatW-1:0] StAdded = 2'd0;
  localparam logic [StatW-1:0] StOwner = 2'd1;
  localparam logic [StatW-1:0] StDup   = 2'd2;
  localparam logic [StatW-1:0] StFull  = 2'd3;

  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic             capture;   // latch request and compare results
    logic             insert;    // shift cells and write id
    logic             load_out;  // load result register
    logic [StatW-1:0] status;
    logic             found;
  } dsi_cmd_t;

  typedef struct packed {
    logic func;
    logic owner_hit;
    logic present;
    logic full;
  } dsi_sts_t;

endpackage
`default_nettype wire

@@ rtl/dsi_datapath.sv @@
// Datapath: sorted cell chain of ids, count, owner register, result register.
`default_nettype none
`include "dedup_sorted_id_set_core_defines.svh"
module dsi_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [dsi_pkg::IdW-1:0]     cfg_data_i,
  input  wire logic                        req_func_i,
  input  wire logic [dsi_pkg::IdW-1:0]     req_id_i,
  input  wire dsi_pkg::dsi_cmd_t           cmd_i,
  output dsi_pkg::dsi_sts_t                sts_o,
  output logic [dsi_pkg::StatW-1:0]        res_status_o,
  output logic                             res_found_o,
  output logic [dsi_pkg::CntW-1:0]         res_count_o
);
  import dsi_pkg::*;

  logic [IdW-1:0]    store_q [MaxIds];
  logic [IdW-1:0]    store_d [MaxIds];
  logic [MaxIds-1:0] lt_q, lt_d, eq_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdW-1:0]    owner_q;
  logic [IdW-1:0]    id_q;
  logic              func_q, present_q, owner_hit_q;
  logic [StatW-1:0]  status_q;
  logic              found_q;
  logic [CntW-1:0]   res_count_q;

  // per-cell compare against the incoming id; cells past the count are ignored
  for (genvar i = 0; i < MaxIds; i++) begin : g_cell
    always_comb begin
      lt_d[i] = (CntW'(i) < count_q) && (store_q[i] < req_id_i);
      eq_d[i] = (CntW'(i) < count_q) && (store_q[i] == req_id_i);
    end

    // insert: cells below the slot keep, the slot takes the id, above shift up
    if (i == 0) begin : g_head
      always_comb begin
        store_d[i] = store_q[i];
        if (cmd_i.insert && !lt_q[i]) store_d[i] = id_q;
      end
    end else begin : g_body
      always_comb begin
        store_d[i] = store_q[i];
        if (cmd_i.insert && !lt_q[i]) begin
          store_d[i] = lt_q[i-1] ? id_q : store_q[i-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      store_q[i] <= store_d[i];
    end
  end

  assign count_d = cmd_i.insert ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      owner_q <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) owner_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lt_q        <= lt_d;
      id_q        <= req_id_i;
      func_q      <= req_func_i;
      present_q   <= |eq_d;
      owner_hit_q <= (req_id_i == owner_q);
    end
    if (cmd_i.load_out) begin
      status_q    <= cmd_i.status;
      found_q     <= cmd_i.found;
      res_count_q <= count_d;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.owner_hit = owner_hit_q;
  assign sts_o.present   = present_q;
  assign sts_o.full      = (count_q == CntW'(MaxIds));

  assign res_status_o = status_q;
  assign res_found_o  = found_q;
  assign res_count_o  = res_count_q;

  `DSI_ASSERT_ALW(a_count_range, count_q <= CntW'(MaxIds), "count beyond capacity")
  `DSI_ASSERT_IMP(a_insert_legal, cmd_i.insert, !present_q && !owner_hit_q && !sts_o.full,
                  "insert of refused id")
  `DSI_ASSERT_NXT(a_insert_count, cmd_i.insert, count_q == $past(count_q) + CntW'(1),
                  "count did not advance on insert")

endmodule
`default_nettype wire

@@ rtl/dsi_ctrl.sv @@
// Controller: request sequencing, add/query decision, result handshake.
`default_nettype none
`include "dedup_sorted_id_set_core_defines.svh"
module dsi_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire dsi_pkg::dsi_sts_t  sts_i,
  output dsi_pkg::dsi_cmd_t       cmd_o
);
  import dsi_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = in_valid_i && in_ready_o;
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;

    priority if (sts_i.func == FuncQuery) begin
      cmd_o.found  = sts_i.present;
      cmd_o.status = StAdded;
    end else if (sts_i.owner_hit) begin
      cmd_o.status = StOwner;
    end else if (sts_i.present) begin
      cmd_o.status = StDup;
    end else if (sts_i.full) begin
      cmd_o.status = StFull;
    end else begin
      cmd_o.status = StAdded;
    end

    unique case (state_q)
      StIdle: begin
        if (cmd_o.capture) state_d = StExec;
      end
      StExec: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.insert   = (sts_i.func == FuncAdd) && (cmd_o.status == StAdded);
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DSI_ASSERT_NXT(a_capture_exec, cmd_o.capture, state_q == StExec,
                  "capture did not enter exec")
  `DSI_ASSERT_NXT(a_load_valid, cmd_o.load_out, out_valid_q, "result lost after load")
  `DSI_ASSERT_IMP(a_insert_slot, cmd_o.insert, state_q == StExec && out_free,
                  "insert without free result slot")

endmodule
`default_nettype wire

@@ rtl/dedup_sorted_id_set_core.sv @@
// Top level of the dedup sorted id set: stream ports, controller and datapath.
// Keeps up to 64 distinct 31-bit user ids in ascending order plus their count.
// An add (tuser 0) inserts the id unless it equals owner_id, is already held or
// the set is full; a query (tuser 1) reports presence. Each request gives one
// result beat. On the accept edge every cell of the id chain compares itself
// to the id and the results are registered; in the exec state the controller
// decides the status and shifts the upper cells by one to open the slot. A new
// request is taken while a result beat still waits; its exec step holds until
// the result register is free. owner_id is written through the cfg channel,
// which is always ready and should only be used while no request is in flight.
`default_nettype none
module dedup_sorted_id_set_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dsi_pkg::IdW-1:0]       cfg_data_i,     // owner_id
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dsi_pkg::InDataW-1:0]   s_axis_tdata,   // user_id[30:0], pad
  input  wire logic                          s_axis_tuser,   // func
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [dsi_pkg::OutDataW-1:0]       m_axis_tdata    // status, found, like_count, pad
);
  import dsi_pkg::*;

  dsi_cmd_t         cmd;
  dsi_sts_t         sts;
  logic [StatW-1:0] res_status;
  logic             res_found;
  logic [CntW-1:0]  res_count;

  assign cfg_ready_o = 1'b1;

  dsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsi_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .req_func_i   (s_axis_tuser),
    .req_id_i     (s_axis_tdata[IdW-1:0]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_status_o (res_status),
    .res_found_o  (res_found),
    .res_count_o  (res_count)
  );

  assign m_axis_tdata = OutDataW'({res_count, res_found, res_status});

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Stream-level testbench for the sorted, duplicate-free like-id set core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsi_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 400000;
  localparam int PhaseItems   = 430;

  typedef struct packed {
    logic           func;
    logic [IdW-1:0] user_id;
  } like_req_t;

  // same bit order as m_axis_tdata: status lowest, then found, then like_count
  typedef struct packed {
    logic [CntW-1:0]  like_count;
    logic             found;
    logic [StatW-1:0] status;
  } like_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [IdW-1:0]      cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  like_req_t      queued_requests[$];
  like_result_t   awaited_results[$];
  logic [IdW-1:0] liked_ids[$];  // predicted set contents, ascending
  logic [IdW-1:0] issued_ids[$]; // ids already sent, for duplicates and neighbors
  logic [IdW-1:0] owner_reg = '0;

  int  src_idle_pct  = 0;
  int  sink_idle_pct = 0;
  bit  req_taken     = 1'b0;
  int  cycle_count   = 0;
  int  error_count   = 0;
  int  request_count = 0;
  int  result_count  = 0;
  int  status_hits[4] = '{0, 0, 0, 0};
  int  query_found   = 0;
  int  query_missed  = 0;

  dedup_sorted_id_set_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Sorted insert-if-absent; owner check first, then duplicate, then full.
  function automatic like_result_t predict_like_result(logic func, logic [IdW-1:0] id);
    like_result_t res;
    int           pos;
    bit           present;
    res = '0;
    pos = 0;
    while (pos < liked_ids.size() && liked_ids[pos] < id) pos++;
    present = (pos < liked_ids.size()) && (liked_ids[pos] == id);
    if (func == FuncQuery) begin
      res.found = present;
    end else if (id == owner_reg) begin
      res.status = StOwner;
    end else if (present) begin
      res.status = StDup;
    end else if (liked_ids.size() >= MaxIds) begin
      res.status = StFull;
    end else begin
      liked_ids.insert(pos, id);
      res.status = StAdded;
    end
    res.like_count = CntW'(liked_ids.size());
    return res;
  endfunction

  function automatic logic [IdW-1:0] pick_user_id();
    logic [IdW-1:0] id;
    int             sel;
    sel = $urandom_range(99);
    if (sel < 35 && issued_ids.size() > 0) begin
      id = issued_ids[$urandom_range(issued_ids.size() - 1)];
    end else if (sel < 45 && issued_ids.size() > 0) begin
      id = issued_ids[$urandom_range(issued_ids.size() - 1)];
      id = $urandom_range(1) ? id + 1'b1 : id - 1'b1;
    end else if (sel < 50) begin
      id = owner_reg;
    end else if (sel < 53) begin
      id = '0;
    end else if (sel < 56) begin
      id = '1;
    end else begin
      id = IdW'($urandom());
    end
    issued_ids.push_back(id);
    return id;
  endfunction

  task automatic queue_request(logic func, logic [IdW-1:0] id);
    queued_requests.push_back('{func: func, user_id: id});
  endtask

  task automatic queue_random(int count, int add_pct);
    repeat (count) begin
      queue_request(($urandom_range(99) < add_pct) ? FuncAdd : FuncQuery, pick_user_id());
    end
  endtask

  task automatic wait_for_idle();
    while (queued_requests.size() != 0 || awaited_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_owner(logic [IdW-1:0] id);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    owner_reg = id;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // request driver: valid only drops or changes after a beat was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (queued_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        like_req_t req;
        req = queued_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'(req.user_id);
        s_axis_tuser  <= req.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      like_result_t res;
      res = predict_like_result(s_axis_tuser, s_axis_tdata[IdW-1:0]);
      awaited_results.push_back(res);
      req_taken = 1'b1;
      request_count++;
      if (s_axis_tuser == FuncQuery) begin
        if (res.found) query_found++;
        else query_missed++;
      end else begin
        status_hits[res.status]++;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      like_result_t got, want;
      got = like_result_t'(m_axis_tdata[OutRawW-1:0]);
      result_count++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: status %0d found %0d count %0d",
                 $time, got.status, got.found, got.like_count);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, got.status);
          error_count++;
        end
        if (got.found != want.found) begin
          $display("%0t: found mismatch: expected %0d, got %0d",
                   $time, want.found, got.found);
          error_count++;
        end
        if (got.like_count != want.like_count) begin
          $display("%0t: like_count mismatch: expected %0d, got %0d",
                   $time, want.like_count, got.like_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, awaited_results.size());
    $display("dedup_sorted_id_set_core test failed");
    $finish;
  end

  initial begin
    logic [IdW-1:0] held_owner;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(posedge clk_i);

    // directed: owner 0, empty-set lookups, extremes, duplicates
    src_idle_pct  = 36;
    sink_idle_pct = 81;
    write_owner('0);
    queue_request(FuncQuery, '0);          // owner lookup on empty set
    queue_request(FuncAdd,   '0);          // owner refused
    queue_request(FuncAdd,   '1);
    queue_request(FuncAdd,   IdW'(1));
    queue_request(FuncAdd,   '1);          // duplicate
    queue_request(FuncQuery, '1);
    queue_request(FuncQuery, IdW'(31'h7fff_fffe));
    queue_request(FuncAdd,   IdW'(31'h5555_5555));
    queue_request(FuncAdd,   IdW'(31'h2aaa_aaaa));
    queue_request(FuncAdd,   IdW'(31'h4000_0000));
    queue_request(FuncAdd,   IdW'(31'h3fff_ffff));
    queue_request(FuncQuery, IdW'(1));
    queue_request(FuncQuery, IdW'(2));
    queue_request(FuncAdd,   IdW'(1));     // duplicate in the low end
    queue_request(FuncQuery, '0);
    wait_for_idle();

    // owner at the top of the range; slow fill
    write_owner('1);
    queue_random(PhaseItems, 35);
    wait_for_idle();

    src_idle_pct  = 81;
    sink_idle_pct = 36;
    write_owner(IdW'($urandom()));
    queue_random(PhaseItems, 60);
    wait_for_idle();

    // owner becomes an id that is already held: it stays, further adds of it refused
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    held_owner = (liked_ids.size() > 0) ? liked_ids[$urandom_range(liked_ids.size() - 1)]
                                        : IdW'($urandom());
    write_owner(held_owner);
    queue_request(FuncQuery, held_owner);
    queue_request(FuncAdd,   held_owner);
    queue_random(PhaseItems, 50);
    wait_for_idle();

    $display("%0d requests, %0d results; adds: %0d new, %0d owner, %0d dup, %0d full",
             request_count, result_count, status_hits[StAdded], status_hits[StOwner],
             status_hits[StDup], status_hits[StFull]);
    $display("queries: %0d hits, %0d misses; final set size %0d, 4 owner settings",
             query_found, query_missed, liked_ids.size());
    if (error_count == 0) begin
      $display("dedup_sorted_id_set_core test passed");
    end else begin
      $display("dedup_sorted_id_set_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/dsi_pkg.sv
rtl/dsi_datapath.sv
rtl/dsi_ctrl.sv
rtl/dedup_sorted_id_set_core.sv
test/tb.sv
